[src/xeu_pkg.sv]
`default_nettype none

package xeu_pkg;

  localparam int ENT_COUNT  = 5;
  localparam int ENT_MAXLEN = 6;
  localparam int HOLD_DEPTH = 5;
  localparam int XEU_FIFO_DEPTH = 2;

  localparam logic [7:0] AMP_CHAR = 8'h26;

  localparam logic [0:ENT_COUNT-1][0:ENT_MAXLEN-1][7:0] ENT_TEXT = '{
    '{8'h26, 8'h61, 8'h6d, 8'h70, 8'h3b, 8'h00},
    '{8'h26, 8'h61, 8'h70, 8'h6f, 8'h73, 8'h3b},
    '{8'h26, 8'h71, 8'h75, 8'h6f, 8'h74, 8'h3b},
    '{8'h26, 8'h6c, 8'h74, 8'h3b, 8'h00, 8'h00},
    '{8'h26, 8'h67, 8'h74, 8'h3b, 8'h00, 8'h00}
  };

  localparam logic [0:ENT_COUNT-1][2:0] ENT_LEN = '{3'd5, 3'd6, 3'd6, 3'd4, 3'd4};

  localparam logic [0:ENT_COUNT-1][7:0] ENT_CHAR = '{8'h26, 8'h27, 8'h22, 8'h3c, 8'h3e};

  // One decode job: a run of held bytes, then at most one more byte.
  typedef struct packed {
    logic [0:HOLD_DEPTH-1][7:0] pend;
    logic [2:0]                 n_pend;
    logic                       has_tail;
    logic [7:0]                 tail;
    logic                       last;
  } xeu_job_t;

endpackage

`default_nettype wire

[src/xeu_if.sv]
`default_nettype none

interface xeu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink (input valid, input text_byte, input last_byte, output ready);
endinterface

interface xeu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

[src/xeu_front.sv]
`default_nettype none

module xeu_front import xeu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  xeu_in_if.sink        in_ch,
  input  wire logic     q_full,
  output logic          q_push,
  output xeu_job_t      q_job
);

  logic [0:HOLD_DEPTH-1][7:0] pend_r;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic                       accept;
  logic                       full_hit, prefix, same;
  logic [7:0]                 rep_char;
  logic [3:0]                 len1;
  logic                       wr_en;
  logic [2:0]                 wr_idx;
  logic                       is_amp;
  logic [7:0]                 b;
  logic                       last;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.text_byte;
  assign last        = in_ch.last_byte;
  assign is_amp      = (b == AMP_CHAR);
  assign len1        = {1'b0, cnt_r} + 4'd1;

  always_comb begin
    full_hit = 1'b0;
    prefix   = 1'b0;
    rep_char = 8'h00;
    same     = 1'b0;
    for (int e = 0; e < ENT_COUNT; e++) begin
      same = ({1'b0, ENT_LEN[e]} >= len1);
      for (int i = 0; i < HOLD_DEPTH; i++) begin
        if ((3'(i) < cnt_r) && (ENT_TEXT[e][i] != pend_r[i])) begin
          same = 1'b0;
        end
      end
      if (ENT_TEXT[e][cnt_r] != b) begin
        same = 1'b0;
      end
      if (same) begin
        if ({1'b0, ENT_LEN[e]} == len1) begin
          full_hit = 1'b1;
          rep_char = ENT_CHAR[e];
        end else begin
          prefix = 1'b1;
        end
      end
    end
  end

  always_comb begin
    q_job          = '0;
    q_job.pend     = pend_r;
    q_job.tail     = b;
    q_job.last     = last;
    cnt_nxt        = cnt_r;
    wr_en          = 1'b0;
    wr_idx         = 3'd0;
    if (cnt_r == 3'd0) begin
      q_job.has_tail = !is_amp || last;
      if (is_amp && !last) begin
        wr_en   = 1'b1;
        cnt_nxt = 3'd1;
      end
    end else if (full_hit) begin
      q_job.has_tail = 1'b1;
      q_job.tail     = rep_char;
      cnt_nxt        = 3'd0;
    end else if (prefix && (cnt_r < 3'(HOLD_DEPTH))) begin
      if (last) begin
        q_job.n_pend   = cnt_r;
        q_job.has_tail = 1'b1;
        cnt_nxt        = 3'd0;
      end else begin
        wr_en   = 1'b1;
        wr_idx  = cnt_r;
        cnt_nxt = len1[2:0];
      end
    end else begin
      q_job.n_pend = cnt_r;
      if (is_amp && !last) begin
        wr_en   = 1'b1;
        cnt_nxt = 3'd1;
      end else begin
        q_job.has_tail = 1'b1;
        cnt_nxt        = 3'd0;
      end
    end
  end

  assign q_push = accept && (q_job.has_tail || (q_job.n_pend != 3'd0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 3'd0;
    end else if (accept) begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && wr_en) begin
      pend_r[wr_idx] <= b;
    end
  end

endmodule

`default_nettype wire

[src/xeu_fifo.sv]
`default_nettype none

module xeu_fifo import xeu_pkg::*; #(
  parameter int Depth = XEU_FIFO_DEPTH
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire xeu_job_t push_job,
  output logic          full,
  input  wire logic     pop,
  output xeu_job_t      pop_job,
  output logic          empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  xeu_job_t            mem_r [Depth];
  logic [PtrW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0]     cnt_r;
  logic                do_push, do_pop;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign pop_job = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

[src/xeu_back.sv]
`default_nettype none

module xeu_back import xeu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire xeu_job_t q_job,
  input  wire logic     q_empty,
  output logic          q_pop,
  xeu_out_if.source     out_ch
);

  xeu_job_t   cur_r;
  logic       cur_vld_r;
  logic [2:0] idx_r;
  logic       out_vld_r, out_last_r;
  logic [7:0] out_byte_r;
  logic [2:0] total;
  logic       is_final, load, emit, cur_free;
  logic [7:0] sel_byte;

  assign total    = cur_r.n_pend + {2'b00, cur_r.has_tail};
  assign is_final = (idx_r == total - 3'd1);
  assign sel_byte = (idx_r < cur_r.n_pend) ? cur_r.pend[idx_r] : cur_r.tail;
  assign load     = !out_vld_r || out_ch.ready;
  assign emit     = cur_vld_r && load;
  assign cur_free = !cur_vld_r || (emit && is_final);
  assign q_pop    = !q_empty && cur_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r <= 1'b0;
      idx_r     <= 3'd0;
      out_vld_r <= 1'b0;
    end else begin
      if (q_pop) begin
        cur_vld_r <= 1'b1;
        idx_r     <= 3'd0;
      end else if (emit) begin
        if (is_final) begin
          cur_vld_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 3'd1;
        end
      end
      if (load) begin
        out_vld_r <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_r <= q_job;
    end
    if (emit) begin
      out_byte_r <= sel_byte;
      out_last_r <= cur_r.last && is_final;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.out_last = out_last_r;

endmodule

`default_nettype wire

[src/xml_entity_unescaper_unit.sv]
// Path: a beat's decoded bytes are registered in the job queue, the current job and the output.
// Throughput: one input beat per cycle while each beat yields at most one byte and out_ch is
// ready; the serializer sends one byte per cycle unless stalled, so multi-byte beats hold it.
// A job queue between the classifier and the serializer absorbs short bursts.
// Reset: synchronous, active low; the held prefix count, queue and output are cleared.
`default_nettype none

module xml_entity_unescaper_unit import xeu_pkg::*; #(
  parameter int FifoDepth = XEU_FIFO_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  xeu_in_if.sink    in_ch,
  xeu_out_if.source out_ch
);

  logic     q_push, q_full, q_pop, q_empty;
  xeu_job_t push_job, pop_job;

  xeu_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_job  (push_job)
  );

  xeu_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .empty    (q_empty)
  );

  xeu_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_job   (pop_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

[dv/xeu_checker.sv]
`timescale 1ns / 100ps

module xeu_checker (
  input  logic clk,
  input  logic rst_n,
  xeu_in_if    in_mon,
  xeu_out_if   out_mon,
  output int   errors,
  output int   awaited
);

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } decoded_t;

  localparam int NUM_ENT = 5;
  localparam int MAX_HELD = 5;

  localparam logic [0:NUM_ENT-1][47:0] ENT_SEQ = {
    {"&amp;", 8'h00}, "&apos;", "&quot;", {"&lt;", 16'h0000}, {"&gt;", 16'h0000}
  };
  localparam logic [0:NUM_ENT-1][2:0] ENT_SIZE = {3'd5, 3'd6, 3'd6, 3'd4, 3'd4};
  localparam logic [0:NUM_ENT-1][7:0] ENT_GLYPH = {"&", "'", "\"", "<", ">"};
  localparam logic [7:0] AMPERSAND = "&";

  decoded_t   want_q[$];
  decoded_t   head;
  logic [7:0] held[MAX_HELD];
  int         held_n;
  int         miss_count;

  assign errors = miss_count;

  function automatic logic [7:0] ent_char_at(input int e, input int i);
    return ENT_SEQ[e][47 - 8 * i -: 8];
  endfunction

  task automatic report_miss(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    miss_count++;
  endtask

  task automatic emit_byte(input logic [7:0] b);
    want_q.push_back('{ch: b, fin: 1'b0});
  endtask

  task automatic flush_held();
    for (int i = 0; i < held_n; i++) emit_byte(held[i]);
    held_n = 0;
  endtask

  task automatic take_fresh(input logic [7:0] b);
    if (b == AMPERSAND) begin
      held[0] = b;
      held_n = 1;
    end else begin
      emit_byte(b);
    end
  endtask

  task automatic decode_beat(input logic [7:0] b, input logic fin);
    int         base;
    int         span;
    bit         whole;
    bit         grows;
    bit         same;
    logic [7:0] glyph;
    base = want_q.size();
    if (held_n == 0) begin
      take_fresh(b);
    end else begin
      span = held_n + 1;
      whole = 1'b0;
      grows = 1'b0;
      glyph = '0;
      for (int e = 0; e < NUM_ENT; e++) begin
        if (int'(ENT_SIZE[e]) >= span) begin
          same = (ent_char_at(e, held_n) == b);
          for (int i = 0; i < held_n; i++) begin
            if (ent_char_at(e, i) != held[i]) same = 1'b0;
          end
          if (same && int'(ENT_SIZE[e]) == span) begin
            whole = 1'b1;
            glyph = ENT_GLYPH[e];
          end else if (same) begin
            grows = 1'b1;
          end
        end
      end
      if (whole) begin
        held_n = 0;
        emit_byte(glyph);
      end else if (grows && held_n < MAX_HELD) begin
        held[held_n] = b;
        held_n = span;
      end else begin
        flush_held();
        take_fresh(b);
      end
    end
    if (fin) begin
      flush_held();
      if (want_q.size() > base) want_q[want_q.size() - 1].fin = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_n = 0;
      miss_count = 0;
      want_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) decode_beat(in_mon.text_byte, in_mon.last_byte);
      if (out_mon.valid && out_mon.ready) begin
        if (want_q.size() == 0) begin
          report_miss($sformatf("unexpected beat, byte %02h last %0b",
                                out_mon.out_byte, out_mon.out_last));
        end else begin
          head = want_q.pop_front();
          if (out_mon.out_byte !== head.ch)
            report_miss($sformatf("out_byte %02h, wanted %02h", out_mon.out_byte, head.ch));
          if (out_mon.out_last !== head.fin)
            report_miss($sformatf("out_last %0b, wanted %0b on byte %02h",
                                  out_mon.out_last, head.fin, head.ch));
        end
      end
    end
    awaited <= want_q.size();
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps

module tb;
  import xeu_pkg::*;

  localparam int NUM_BEATS = 320;
  localparam int QUIET_LIMIT = 2000;

  logic clk;
  logic rst_n;
  logic calm;
  int   fail_count;
  int   awaited;
  int   sent;
  int   quiet;

  xeu_in_if  in_ch ();
  xeu_out_if out_ch ();

  xml_entity_unescaper_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  xeu_checker u_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_mon  (in_ch),
    .out_mon (out_ch),
    .errors  (fail_count),
    .awaited (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= calm || ($urandom_range(99) >= 32);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic fin);
    while (!calm && $urandom_range(99) < 32) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.text_byte <= b;
    in_ch.last_byte <= fin;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_text(input string s, input logic fin);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], fin && (i == s.len() - 1));
  endtask

  initial begin
    logic [7:0] tok[$];
    int         pick;
    int         e;
    int         n;
    int         j;
    bit         ends;
    rst_n <= 1'b0;
    calm <= 1'b0;
    sent = 0;
    in_ch.valid <= 1'b0;
    in_ch.text_byte <= 8'h20;
    in_ch.last_byte <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_text("&apos;&quot;", 1'b1);
    send_text("&amp;&a&lt", 1'b1);
    send_text("&gt;", 1'b0);
    send_text("&apos", 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h01, 1'b1);
    send_text("&", 1'b1);

    while (sent < NUM_BEATS) begin
      calm <= (sent >= 150 && sent < 215);
      tok.delete();
      pick = $urandom_range(99);
      e = $urandom_range(ENT_COUNT - 1);
      ends = ($urandom_range(7) == 0);
      if (pick < 72) begin
        n = (pick >= 45 && pick < 60) ? $urandom_range(int'(ENT_LEN[e]) - 1, 1)
                                        : int'(ENT_LEN[e]);
        for (int i = 0; i < n; i++) tok.push_back(ENT_TEXT[e][i]);
        if (pick >= 60) begin
          j = $urandom_range(n - 1, 1);
          tok[j] = (($urandom_range(1) == 0) ? AMP_CHAR : 8'($urandom_range(255, 1)));
        end
      end else if (pick < 80) begin
        tok.push_back(AMP_CHAR);
      end else begin
        n = $urandom_range(4, 1);
        for (int i = 0; i < n; i++) tok.push_back(8'($urandom_range(255, 1)));
      end
      foreach (tok[i]) send_beat(tok[i], ends && (i == tok.size() - 1));
    end
    in_ch.valid <= 1'b0;

    do @(posedge clk); while (awaited != 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
